/* rtl/pbm_pkg.sv */
// Shared constants, mode codes and the blend color table for the blend channel.
package pbm_pkg;

	localparam logic [16:0] FX_ONE = 17'h10000;
	localparam logic [16:0] FX_HALF = 17'h08000;

	localparam int unsigned DIV_STAGES = 4;
	localparam int unsigned DIV_STEPS = 4;

	// floor(d/100) = (d*RECIP_100) >> RECIP_SHIFT, exact for d below 2**23
	localparam logic [23:0] RECIP_100 = 24'd10737419;
	localparam int unsigned RECIP_SHIFT = 30;
	localparam logic [6:0] PCT_MAX = 7'd100;

	typedef enum logic [3:0] {
		MODE_NORMAL    = 4'd0,
		MODE_MULTIPLY  = 4'd1,
		MODE_LINBURN   = 4'd2,
		MODE_DARKEN    = 4'd3,
		MODE_COLORBURN = 4'd4,
		MODE_LIGHTEN   = 4'd5,
		MODE_SCREEN    = 4'd6,
		MODE_OVERLAY   = 4'd7,
		MODE_SOFT      = 4'd8,
		MODE_HARD      = 4'd9,
		MODE_LINDODGE  = 4'd10,
		MODE_PASS      = 4'd11
	} mode_t;

	typedef logic [16:0] ytbl_t [256];

	// round(s*ONE/255)
	function automatic ytbl_t gen_ytbl();
		ytbl_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = 17'(((i * 65536) + 127) / 255);
		end
		return t;
	endfunction

	localparam ytbl_t Y_TBL = gen_ytbl();

endpackage

/* rtl/pbm_if.sv */
// Request channels for the blend channel: input item and result item.
interface pbm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] channel_premul;
	logic [7:0] pixel_alpha;
	logic [7:0] blend_color;
	logic [3:0] mode;
	logic [6:0] opacity_pct;

	modport source(output valid, channel_premul, pixel_alpha, blend_color, mode, opacity_pct,
		input ready);
	modport sink(input valid, channel_premul, pixel_alpha, blend_color, mode, opacity_pct,
		output ready);
endinterface

interface pbm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_premul;

	modport source(output valid, result_premul, input ready);
	modport sink(input valid, result_premul, output ready);
endinterface

/* rtl/premultiplied_blend_mode_channel.sv */
// Top level: one premultiplied channel through a separable blend mode.
//
//  channel | dir | payload                                              | role
//  din     | in  | channel_premul, pixel_alpha, blend_color, mode, pct  | one channel request
//  dout    | out | result_premul (8 fractional bits)                    | one result per request
//
// Fourteen register stages; one request accepted per cycle while dout is not stalled.
// Two 4-stage dividers set the depth: un-premultiply, then color burn.
// A stall at dout freezes the whole pipe; din.ready drops only while the
// last stage holds a result that is not taken. Reset clears the valid bits.
module premultiplied_blend_mode_channel (
	input  logic          clk,
	input  logic          arst_n,
	pbm_in_if.sink        din,
	pbm_out_if.source     dout
);
	import pbm_pkg::*;

	localparam int unsigned NSTG = 14;

	typedef struct packed {
		logic [7:0]  premul;
		logic [7:0]  alpha;
		logic [16:0] y;
		logic [3:0]  mode;
		logic [6:0]  pct;
		logic        alpha0;
		logic        xsat;
	} side_t;

	typedef struct packed {
		logic [16:0] x;
		logic [16:0] y;
		logic [3:0]  mode;
		logic [6:0]  pct;
		logic [7:0]  alpha;
		logic [7:0]  premul;
		logic        alpha0;
	} core_t;

	typedef struct packed {
		core_t       c;
		logic        bsat;
		logic [16:0] mul_xy;
		logic [17:0] mul2_xy;
		logic [17:0] mul2_inv;
		logic [16:0] mul_xx;
		logic [16:0] mul_xnx;
		logic [17:0] soft_mix;
	} mid_t;

	typedef struct packed {
		logic [16:0] x;
		logic [16:0] b;
		logic [6:0]  pct;
		logic [7:0]  alpha;
		logic [7:0]  premul;
		logic        alpha0;
	} t11_t;

	typedef struct packed {
		logic [22:0] d;
		logic        neg;
		logic [16:0] x;
		logic [7:0]  alpha;
		logic [7:0]  premul;
		logic        alpha0;
	} t12_t;

	typedef struct packed {
		logic [16:0] q;
		logic        neg;
		logic [16:0] x;
		logic [7:0]  alpha;
		logic [7:0]  premul;
		logic        alpha0;
	} t13_t;

	logic [NSTG-1:0] vld_s;
	logic            en;

	assign en = !vld_s[NSTG-1] || dout.ready;
	assign din.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-2:0], din.valid};
		end
	end

	// stage 1: divider operands, blend color lookup
	side_t       s1_nx;
	logic [16:0] dnum_nx, dden_nx;
	side_t       side_s1;
	logic [16:0] dnum_s1, dden_s1;
	logic [15:0] dlow_s1;

	always_comb begin
		s1_nx.premul = din.channel_premul;
		s1_nx.alpha  = din.pixel_alpha;
		s1_nx.y      = Y_TBL[din.blend_color];
		s1_nx.mode   = din.mode;
		s1_nx.pct    = (din.opacity_pct > PCT_MAX) ? PCT_MAX : din.opacity_pct;
		s1_nx.alpha0 = (din.pixel_alpha == 8'd0);
		s1_nx.xsat   = (din.channel_premul >= din.pixel_alpha);
		dden_nx      = 17'(din.pixel_alpha) * 17'd510;
		dnum_nx      = 17'(din.channel_premul) * 17'd510 + 17'(din.pixel_alpha);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= s1_nx;
			dnum_s1 <= dnum_nx;
			dden_s1 <= dden_nx;
			dlow_s1 <= dden_nx[16:1];
		end
	end

	// stages 2..5: un-premultiply division
	logic [15:0] xq;
	side_t       side_s2_5 [DIV_STAGES];

	pbm_div u_xdiv (
		.clk (clk),
		.en  (en),
		.num (dnum_s1),
		.low (dlow_s1),
		.den (dden_s1),
		.quo (xq)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2_5[0] <= side_s1;
			for (int k = 1; k < DIV_STAGES; k++) begin
				side_s2_5[k] <= side_s2_5[k-1];
			end
		end
	end

	// stage 6
	side_t       sd5;
	core_t       c6_nx;
	core_t       core_s6;
	logic [16:0] nb_s6;
	logic        bsat_s6;

	assign sd5 = side_s2_5[DIV_STAGES-1];

	always_comb begin
		c6_nx.x      = sd5.xsat ? FX_ONE : {1'b0, xq};
		c6_nx.y      = sd5.y;
		c6_nx.mode   = sd5.mode;
		c6_nx.pct    = sd5.pct;
		c6_nx.alpha  = sd5.alpha;
		c6_nx.premul = sd5.premul;
		c6_nx.alpha0 = sd5.alpha0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			core_s6 <= c6_nx;
			nb_s6   <= FX_ONE - c6_nx.x;
			// quotient reaches ONE: burn result is zero, also covers a black blend color
			bsat_s6 <= ((FX_ONE - c6_nx.x) >= sd5.y);
		end
	end

	// stages 7..10 alongside the color burn division
	logic [15:0] bq;

	pbm_div u_bdiv (
		.clk (clk),
		.en  (en),
		.num (nb_s6),
		.low (core_s6.y[16:1]),
		.den (core_s6.y),
		.quo (bq)
	);

	logic [33:0] p_xy, p_inv, p_xx, p_xnx;
	logic [16:0] inv_y;
	mid_t        m7_nx;
	mid_t        mid_s7_10 [4];
	logic [32:0] p_soft;
	mid_t        m8_nx;

	always_comb begin
		inv_y = FX_ONE - core_s6.y;
		p_xy  = 34'(core_s6.x) * 34'(core_s6.y);
		p_inv = 34'(nb_s6) * 34'(inv_y);
		p_xx  = 34'(core_s6.x) * 34'(core_s6.x);
		p_xnx = 34'(core_s6.x) * 34'(nb_s6);
		m7_nx.c        = core_s6;
		m7_nx.bsat     = bsat_s6;
		m7_nx.mul_xy   = 17'((35'(p_xy) + 35'(FX_HALF)) >> 16);
		m7_nx.mul2_xy  = 18'(({p_xy, 1'b0} + 35'(FX_HALF)) >> 16);
		m7_nx.mul2_inv = 18'(({p_inv, 1'b0} + 35'(FX_HALF)) >> 16);
		m7_nx.mul_xx   = 17'((35'(p_xx) + 35'(FX_HALF)) >> 16);
		m7_nx.mul_xnx  = 17'((35'(p_xnx) + 35'(FX_HALF)) >> 16);
		m7_nx.soft_mix = '0;
	end

	always_comb begin
		p_soft = 33'(mid_s7_10[0].c.y) * 33'(mid_s7_10[0].mul_xnx[15:0]);
		m8_nx  = mid_s7_10[0];
		m8_nx.soft_mix = 18'(mid_s7_10[0].mul_xx)
			+ 18'(({p_soft, 1'b0} + 34'(FX_HALF)) >> 16);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s7_10[0] <= m7_nx;
			mid_s7_10[1] <= m8_nx;
			mid_s7_10[2] <= mid_s7_10[1];
			mid_s7_10[3] <= mid_s7_10[2];
		end
	end

	// stage 10: mode select
	mid_t        m10;
	logic [17:0] sum_xy, scr_inv, braw;
	logic [16:0] bclamp;
	t11_t        t11_nx, t11_s11;

	assign m10 = mid_s7_10[3];

	always_comb begin
		sum_xy  = 18'(m10.c.x) + 18'(m10.c.y);
		scr_inv = (m10.mul2_inv > 18'(FX_ONE)) ? 18'd0 : 18'(FX_ONE) - m10.mul2_inv;
		case (mode_t'(m10.c.mode))
			MODE_NORMAL:    braw = 18'(m10.c.y);
			MODE_MULTIPLY:  braw = 18'(m10.mul_xy);
			MODE_LINBURN:   braw = (sum_xy > 18'(FX_ONE)) ? sum_xy - 18'(FX_ONE) : 18'd0;
			MODE_DARKEN:    braw = (m10.c.x < m10.c.y) ? 18'(m10.c.x) : 18'(m10.c.y);
			MODE_COLORBURN: braw = m10.bsat ? 18'd0 : 18'(FX_ONE) - 18'(bq);
			MODE_LIGHTEN:   braw = (m10.c.x > m10.c.y) ? 18'(m10.c.x) : 18'(m10.c.y);
			MODE_SCREEN:    braw = sum_xy - 18'(m10.mul_xy);
			MODE_OVERLAY:   braw = (m10.c.x <= FX_HALF) ? m10.mul2_xy : scr_inv;
			MODE_SOFT:      braw = m10.soft_mix;
			MODE_HARD:      braw = (m10.c.y <= FX_HALF) ? m10.mul2_xy : scr_inv;
			MODE_LINDODGE:  braw = sum_xy;
			default:        braw = 18'(m10.c.x);
		endcase
		bclamp = (braw > 18'(FX_ONE)) ? FX_ONE : braw[16:0];
		t11_nx.x      = m10.c.x;
		t11_nx.b      = bclamp;
		t11_nx.pct    = m10.c.pct;
		t11_nx.alpha  = m10.c.alpha;
		t11_nx.premul = m10.c.premul;
		t11_nx.alpha0 = m10.c.alpha0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t11_s11 <= t11_nx;
		end
	end

	// stage 11: opacity step numerator
	logic [16:0] diff;
	t12_t        t12_nx, t12_s12;

	always_comb begin
		diff = (t11_s11.b >= t11_s11.x) ? t11_s11.b - t11_s11.x : t11_s11.x - t11_s11.b;
		t12_nx.d      = 23'(diff) * 23'(t11_s11.pct) + 23'd50;
		t12_nx.neg    = (t11_s11.b < t11_s11.x);
		t12_nx.x      = t11_s11.x;
		t12_nx.alpha  = t11_s11.alpha;
		t12_nx.premul = t11_s11.premul;
		t12_nx.alpha0 = t11_s11.alpha0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t12_s12 <= t12_nx;
		end
	end

	// stage 12: divide by 100 through the reciprocal
	logic [46:0] p_rc;
	t13_t        t13_nx, t13_s13;

	always_comb begin
		p_rc = 47'(t12_s12.d) * 47'(RECIP_100);
		t13_nx.q      = p_rc[RECIP_SHIFT +: 17];
		t13_nx.neg    = t12_s12.neg;
		t13_nx.x      = t12_s12.x;
		t13_nx.alpha  = t12_s12.alpha;
		t13_nx.premul = t12_s12.premul;
		t13_nx.alpha0 = t12_s12.alpha0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t13_s13 <= t13_nx;
		end
	end

	// stage 13: mix and premultiply
	logic [17:0] omix;
	logic [16:0] oclamp;
	logic [24:0] p_out;
	logic [15:0] res_nx, res_s14;

	always_comb begin
		omix   = t13_s13.neg ? 18'(t13_s13.x) - 18'(t13_s13.q)
		                     : 18'(t13_s13.x) + 18'(t13_s13.q);
		oclamp = (omix > 18'(FX_ONE)) ? FX_ONE : omix[16:0];
		p_out  = 25'(oclamp) * 25'(t13_s13.alpha) + 25'd128;
		// transparent pixel keeps the channel as is
		res_nx = t13_s13.alpha0 ? {t13_s13.premul, 8'h00} : p_out[23:8];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s14 <= res_nx;
		end
	end

	assign dout.valid         = vld_s[NSTG-1];
	assign dout.result_premul = res_s14;

endmodule

/* rtl/pbm_div.sv */
// Pipelined restoring divider: 16 quotient bits, four bits per stage.
module pbm_div (
	input  logic        clk,
	input  logic        en,
	input  logic [16:0] num,
	input  logic [15:0] low,
	input  logic [16:0] den,
	output logic [15:0] quo
);
	import pbm_pkg::*;

	typedef struct packed {
		logic [16:0] rem;
		logic [15:0] low;
		logic [16:0] den;
		logic [15:0] quo;
	} div_st_t;

	function automatic div_st_t div_steps(input div_st_t a);
		div_st_t     r;
		logic [17:0] r2;
		r = a;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r2 = {r.rem, r.low[15]};
			r.low = {r.low[14:0], 1'b0};
			if (r2 >= {1'b0, r.den}) begin
				r2 = r2 - {1'b0, r.den};
				r.quo = {r.quo[14:0], 1'b1};
			end else begin
				r.quo = {r.quo[14:0], 1'b0};
			end
			r.rem = r2[16:0];
		end
		return r;
	endfunction

	div_st_t st_in [DIV_STAGES];
	div_st_t st_s  [DIV_STAGES];

	assign st_in[0] = '{rem: num, low: low, den: den, quo: 16'd0};

	for (genvar k = 1; k < DIV_STAGES; k++) begin : g_link
		assign st_in[k] = st_s[k-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				st_s[k] <= div_steps(st_in[k]);
			end
		end
	end

	assign quo = st_s[DIV_STAGES-1].quo;

endmodule

/* rtl/pbm_chk.sv */
// Port-level checks for the blend channel, bound to the top level.
module pbm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_result
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_result))
		else $error("stalled result changed");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_ready_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_result <= 16'd65280))
		else $error("result out of range");

endmodule

bind premultiplied_blend_mode_channel pbm_chk u_pbm_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (din.ready),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.out_result (dout.result_premul)
);

/* test/tb_premultiplied_blend_mode_channel.sv */
// Testbench for the premultiplied blend mode channel: directed and random requests.
`timescale 1ns / 1ps
module tb_premultiplied_blend_mode_channel;
	import pbm_pkg::*;

	typedef struct packed {
		logic [7:0] premul;
		logic [7:0] alpha;
		logic [7:0] color;
		logic [3:0] mode;
		logic [6:0] pct;
	} chan_req_t;

	logic clk;
	logic arst_n;

	pbm_in_if  din();
	pbm_out_if dout();

	premultiplied_blend_mode_channel i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din.sink),
		.dout(dout.source)
	);

	chan_req_t pending_reqs[$];
	logic [15:0] expected_results[$];
	int n_errors = 0;
	int send_idle_pct = 26;
	int recv_idle_pct = 68;
	int hold_cycles = 0;
	bit stim_done = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [63:0] fxm(logic [63:0] a, logic [63:0] b);
		return (a * b + 64'd32768) >> 16;
	endfunction

	function automatic logic [63:0] fxm2(logic [63:0] a, logic [63:0] b);
		return (2 * a * b + 64'd32768) >> 16;
	endfunction

	function automatic logic [63:0] lo(logic [63:0] a, logic [63:0] b);
		return a < b ? a : b;
	endfunction

	function automatic logic [15:0] blend_channel(chan_req_t r);
		logic [63:0] one, half, x, y, b, o, num, den, q, pct;
		one = 64'd65536;
		half = 64'd32768;
		if (r.alpha == 0)
			return {r.premul, 8'd0};
		pct = (r.pct > PCT_MAX) ? 64'd100 : 64'(r.pct);
		num = (2 * 64'(r.premul) * 255 + 64'(r.alpha)) << 16;
		den = 2 * 64'(r.alpha) * 255;
		x = lo(one, (num + den / 2) / den);
		y = ((64'(r.color) << 16) + 127) / 255;
		case (r.mode)
			MODE_NORMAL:    b = y;
			MODE_MULTIPLY:  b = fxm(x, y);
			MODE_LINBURN:   b = (x + y > one) ? x + y - one : 0;
			MODE_DARKEN:    b = lo(x, y);
			MODE_COLORBURN: begin
				if (y == 0)
					b = 0;
				else begin
					q = (((one - x) << 16) + y / 2) / y;
					b = one - lo(one, q);
				end
			end
			MODE_LIGHTEN:   b = (x > y) ? x : y;
			MODE_SCREEN:    b = x + y - fxm(x, y);
			MODE_OVERLAY:   b = (x <= half) ? fxm2(x, y) : one - lo(one, fxm2(one - x, one - y));
			MODE_SOFT:      b = fxm(x, x) + fxm2(y, fxm(x, one - x));
			MODE_HARD:      b = (y <= half) ? fxm2(x, y) : one - lo(one, fxm2(one - x, one - y));
			MODE_LINDODGE:  b = lo(one, x + y);
			default:        b = x;
		endcase
		b = lo(one, b);
		if (b >= x)
			o = x + ((b - x) * pct + 50) / 100;
		else
			o = x - ((x - b) * pct + 50) / 100;
		o = lo(one, o);
		return 16'((o * 64'(r.alpha) + 128) >> 8);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din.valid <= 0;
		end else begin
			if (din.valid && din.ready)
				expected_results.insert(expected_results.size(),
					blend_channel(chan_req_t'({din.channel_premul, din.pixel_alpha,
					din.blend_color, din.mode, din.opacity_pct})));
			if (!din.valid || din.ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					chan_req_t r;
					r = pending_reqs.pop_front();
					din.valid <= 1;
					din.channel_premul <= r.premul;
					din.pixel_alpha <= r.alpha;
					din.blend_color <= r.color;
					din.mode <= r.mode;
					din.opacity_pct <= r.pct;
				end else begin
					din.valid <= 0;
				end
			end
		end
	end

	// monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.ready <= 0;
		end else begin
			if (dout.valid && dout.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, dout.result_premul);
					n_errors++;
				end else begin
					logic [15:0] e;
					e = expected_results.pop_front();
					if (e !== dout.result_premul) begin
						$display("%0t: result_premul expected %h actual %h", $time, e,
							dout.result_premul);
						n_errors++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				dout.ready <= 0;
			end else begin
				dout.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic add_req(logic [7:0] p, logic [7:0] a, logic [7:0] c, logic [3:0] m,
		logic [6:0] pc);
		chan_req_t r;
		r = '{p, a, c, m, pc};
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic add_random(int n);
		logic [7:0] a;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(5))
				0: a = 8'd0;
				1: a = 8'd255;
				default: a = 8'($urandom_range(255));
			endcase
			// mostly physical premul <= alpha, sometimes not
			add_req(($urandom_range(9) == 0 || a == 0) ? 8'($urandom_range(255))
				: 8'($urandom_range(a)), a, 8'($urandom_range(255)),
				($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11)),
				($urandom_range(9) == 0) ? 7'($urandom_range(127)) :
				($urandom_range(3) == 0) ? 7'(100) : 7'($urandom_range(100)));
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || din.valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 0;
		din.valid = 0;
		din.channel_premul = 0;
		din.pixel_alpha = 0;
		din.blend_color = 0;
		din.mode = MODE_NORMAL;
		din.opacity_pct = 0;
		dout.ready = 0;
		repeat (2) @(posedge clk);
		arst_n = 1;

		// extremes, every mode, transparent pixel, burn on black, bad codes
		for (int m = 0; m < 16; m++)
			add_req(8'd200, 8'd230, 8'd100, 4'(m), 7'd100);
		add_req(8'd77, 8'd0, 8'd255, MODE_SCREEN, 7'd100);
		add_req(8'd255, 8'd0, 8'd0, MODE_NORMAL, 7'd0);
		add_req(8'd50, 8'd128, 8'd0, MODE_COLORBURN, 7'd100);
		add_req(8'd255, 8'd255, 8'd255, MODE_LINDODGE, 7'd127);
		add_req(8'd0, 8'd255, 8'd255, MODE_HARD, 7'd100);
		add_req(8'd255, 8'd1, 8'd128, MODE_OVERLAY, 7'd50);
		add_req(8'd0, 8'd1, 8'd0, MODE_SOFT, 7'd101);
		add_req(8'd128, 8'd255, 8'd128, MODE_SOFT, 7'd0);
		add_random(130);
		drain();

		// receiver blocks long while the sender keeps offering
		add_random(60);
		hold_cycles = 200;
		drain();

		send_idle_pct = 68;
		recv_idle_pct = 26;
		add_random(130);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random(130);
		drain();
		repeat (30) @(posedge clk);

		if (n_errors == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
